@@ hw/rtl/sbalu_pkg.sv @@
// Package for the sixteen-bit ALU with excess register.
// Holds opcodes, sequencer state type and iteration constants.
// No dependencies.
package sbalu_pkg;

    localparam int unsigned DataWidth = 16;
    localparam int unsigned OpWidth   = 5;

    localparam logic [OpWidth-1:0] OP_SET = 5'd0;
    localparam logic [OpWidth-1:0] OP_ADD = 5'd1;
    localparam logic [OpWidth-1:0] OP_SUB = 5'd2;
    localparam logic [OpWidth-1:0] OP_MUL = 5'd3;
    localparam logic [OpWidth-1:0] OP_MLI = 5'd4;
    localparam logic [OpWidth-1:0] OP_DIV = 5'd5;
    localparam logic [OpWidth-1:0] OP_DVI = 5'd6;
    localparam logic [OpWidth-1:0] OP_MOD = 5'd7;
    localparam logic [OpWidth-1:0] OP_MDI = 5'd8;
    localparam logic [OpWidth-1:0] OP_AND = 5'd9;
    localparam logic [OpWidth-1:0] OP_BOR = 5'd10;
    localparam logic [OpWidth-1:0] OP_XOR = 5'd11;
    localparam logic [OpWidth-1:0] OP_SHR = 5'd12;
    localparam logic [OpWidth-1:0] OP_ASR = 5'd13;
    localparam logic [OpWidth-1:0] OP_SHL = 5'd14;
    localparam logic [OpWidth-1:0] OP_ADX = 5'd15;
    localparam logic [OpWidth-1:0] OP_SBX = 5'd16;
    localparam logic [OpWidth-1:0] OP_IFB = 5'd17;
    localparam logic [OpWidth-1:0] OP_IFC = 5'd18;
    localparam logic [OpWidth-1:0] OP_IFE = 5'd19;
    localparam logic [OpWidth-1:0] OP_IFN = 5'd20;
    localparam logic [OpWidth-1:0] OP_IFG = 5'd21;
    localparam logic [OpWidth-1:0] OP_IFA = 5'd22;
    localparam logic [OpWidth-1:0] OP_IFL = 5'd23;
    localparam logic [OpWidth-1:0] OP_IFU = 5'd24;

    // pass counts minus one
    localparam logic [4:0] ITER_HALF = 5'd15;
    localparam logic [4:0] ITER_FULL = 5'd31;

    localparam logic [DataWidth-1:0] ALL_ONES = 16'hffff;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_WRAP
    } alu_state_t;

endpackage

@@ hw/rtl/sixteen_bit_alu_with_excess_register.sv @@
// Sixteen-bit ALU with excess register, top level.
// Depends on sbalu_pkg.
// Throughput: one word at a time; the 17-bit shared add/subtract unit runs
// 16 (multiply, modulo) or 32 (divide) passes; division or modulo by zero skips them.
// Reset (aresetn, synchronous): sequencer idle, output empty, EX and skip flag cleared.
module sixteen_bit_alu_with_excess_register (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_req_type,
    input  logic [15:0] s_b_value,
    input  logic [15:0] s_a_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_result_value,
    output logic        m_write_back,
    output logic        m_was_skipped,
    output logic        m_test_passed,
    output logic [15:0] m_excess_out
);

    sbalu_pkg::alu_state_t state_reg, state_next;

    logic [4:0]  op_reg, op_next;
    logic [15:0] b_reg, b_next;
    logic [15:0] a_reg, a_next;
    logic [15:0] dvsr_reg, dvsr_next;
    logic [15:0] rem_reg, rem_next;
    logic [31:0] dq_reg, dq_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        skip_now_reg, skip_now_next;

    logic [15:0] excess_reg, excess_next;
    logic        skip_pending_reg, skip_pending_next;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_res_reg, out_res_next;
    logic        out_wb_reg, out_wb_next;
    logic        out_skip_reg, out_skip_next;
    logic        out_pass_reg, out_pass_next;
    logic [15:0] out_ex_reg, out_ex_next;

    // shared add/subtract unit
    logic [16:0] add_x, add_y;
    logic        add_sub;
    logic [17:0] add_res;

    logic        is_mul, is_div, is_mod, is_signed_op;
    logic        in_skip, in_a_zero;
    logic [15:0] mag_b, mag_a;
    logic        commit;

    logic [15:0] w_res, w_ex;
    logic        w_wb, w_pass, w_cond;
    logic [31:0] prod, prod_s;
    logic [31:0] shr_v, asr_v, shl_v;
    logic [16:0] add_v;
    logic [17:0] adx_v, sbx_v;
    logic        sh_ge32;

    always_comb begin
        add_res = add_sub ? ({1'b0, add_x} - {1'b0, add_y})
                          : ({1'b0, add_x} + {1'b0, add_y});
    end

    always_comb begin
        is_mul = (s_req_type == sbalu_pkg::OP_MUL) || (s_req_type == sbalu_pkg::OP_MLI);
        is_div = (s_req_type == sbalu_pkg::OP_DIV) || (s_req_type == sbalu_pkg::OP_DVI);
        is_mod = (s_req_type == sbalu_pkg::OP_MOD) || (s_req_type == sbalu_pkg::OP_MDI);
        is_signed_op = (s_req_type == sbalu_pkg::OP_MLI) || (s_req_type == sbalu_pkg::OP_DVI)
                    || (s_req_type == sbalu_pkg::OP_MDI);
        in_skip   = skip_pending_reg;
        in_a_zero = (s_a_value == 16'h0);
        mag_b = (is_signed_op && s_b_value[15]) ? (16'h0 - s_b_value) : s_b_value;
        mag_a = (is_signed_op && s_a_value[15]) ? (16'h0 - s_a_value) : s_a_value;
    end

    // result formation for the word held in the operand registers
    always_comb begin
        prod   = {rem_reg, dq_reg[15:0]};
        prod_s = neg_reg ? (32'h0 - prod) : prod;
        sh_ge32 = |a_reg[15:5];
        shr_v = {b_reg, 16'h0} >> a_reg[4:0];
        asr_v = 32'($signed({b_reg, 16'h0}) >>> a_reg[4:0]);
        shl_v = {16'h0, b_reg} << a_reg[4:0];
        add_v = {1'b0, b_reg} + {1'b0, a_reg};
        adx_v = {2'b0, b_reg} + {2'b0, a_reg} + {2'b0, excess_reg};
        sbx_v = {2'b0, b_reg} - {2'b0, a_reg} + {2'b0, excess_reg};

        w_res  = 16'h0;
        w_ex   = excess_reg;
        w_wb   = 1'b0;
        w_pass = 1'b0;
        w_cond = 1'b0;
        unique case (op_reg)
            sbalu_pkg::OP_SET: begin
                w_wb = 1'b1; w_res = a_reg;
            end
            sbalu_pkg::OP_ADD: begin
                w_wb = 1'b1; w_res = add_v[15:0]; w_ex = {15'h0, add_v[16]};
            end
            sbalu_pkg::OP_SUB: begin
                w_wb = 1'b1; w_res = b_reg - a_reg;
                w_ex = (a_reg > b_reg) ? sbalu_pkg::ALL_ONES : 16'h0;
            end
            sbalu_pkg::OP_MUL, sbalu_pkg::OP_MLI: begin
                w_wb = 1'b1; w_res = prod_s[15:0]; w_ex = prod_s[31:16];
            end
            sbalu_pkg::OP_DIV, sbalu_pkg::OP_DVI: begin
                w_wb = 1'b1;
                if (a_reg == 16'h0) begin
                    w_res = 16'h0; w_ex = 16'h0;
                end else if (neg_reg) begin
                    w_res = 16'h0 - dq_reg[31:16]; w_ex = 16'h0 - dq_reg[15:0];
                end else begin
                    w_res = dq_reg[31:16]; w_ex = dq_reg[15:0];
                end
            end
            sbalu_pkg::OP_MOD, sbalu_pkg::OP_MDI: begin
                w_wb = 1'b1;
                if (a_reg == 16'h0) begin
                    w_res = 16'h0;
                end else begin
                    w_res = neg_reg ? (16'h0 - rem_reg) : rem_reg;
                end
            end
            sbalu_pkg::OP_AND: begin
                w_wb = 1'b1; w_res = b_reg & a_reg;
            end
            sbalu_pkg::OP_BOR: begin
                w_wb = 1'b1; w_res = b_reg | a_reg;
            end
            sbalu_pkg::OP_XOR: begin
                w_wb = 1'b1; w_res = b_reg ^ a_reg;
            end
            sbalu_pkg::OP_SHR: begin
                w_wb = 1'b1;
                w_res = sh_ge32 ? 16'h0 : shr_v[31:16];
                w_ex  = sh_ge32 ? 16'h0 : shr_v[15:0];
            end
            sbalu_pkg::OP_ASR: begin
                w_wb = 1'b1;
                w_res = sh_ge32 ? {16{b_reg[15]}} : asr_v[31:16];
                w_ex  = sh_ge32 ? {16{b_reg[15]}} : asr_v[15:0];
            end
            sbalu_pkg::OP_SHL: begin
                w_wb = 1'b1;
                w_res = sh_ge32 ? 16'h0 : shl_v[15:0];
                w_ex  = sh_ge32 ? 16'h0 : shl_v[31:16];
            end
            sbalu_pkg::OP_ADX: begin
                w_wb = 1'b1; w_res = adx_v[15:0];
                w_ex = {15'h0, |adx_v[17:16]};
            end
            sbalu_pkg::OP_SBX: begin
                w_wb = 1'b1; w_res = sbx_v[15:0];
                if (sbx_v[17]) begin
                    w_ex = sbalu_pkg::ALL_ONES;
                end else begin
                    w_ex = {15'h0, sbx_v[16]};
                end
            end
            sbalu_pkg::OP_IFB: begin
                w_cond = 1'b1; w_pass = |(b_reg & a_reg);
            end
            sbalu_pkg::OP_IFC: begin
                w_cond = 1'b1; w_pass = ~|(b_reg & a_reg);
            end
            sbalu_pkg::OP_IFE: begin
                w_cond = 1'b1; w_pass = (b_reg == a_reg);
            end
            sbalu_pkg::OP_IFN: begin
                w_cond = 1'b1; w_pass = (b_reg != a_reg);
            end
            sbalu_pkg::OP_IFG: begin
                w_cond = 1'b1; w_pass = (b_reg > a_reg);
            end
            sbalu_pkg::OP_IFA: begin
                w_cond = 1'b1; w_pass = ($signed(b_reg) > $signed(a_reg));
            end
            sbalu_pkg::OP_IFL: begin
                w_cond = 1'b1; w_pass = (b_reg < a_reg);
            end
            sbalu_pkg::OP_IFU: begin
                w_cond = 1'b1; w_pass = ($signed(b_reg) < $signed(a_reg));
            end
            default: begin
                w_res = 16'h0;
            end
        endcase
    end

    // sequencer and datapath next state
    always_comb begin
        state_next        = state_reg;
        op_next           = op_reg;
        b_next            = b_reg;
        a_next            = a_reg;
        dvsr_next         = dvsr_reg;
        rem_next          = rem_reg;
        dq_next           = dq_reg;
        cnt_next          = cnt_reg;
        neg_next          = neg_reg;
        skip_now_next     = skip_now_reg;
        excess_next       = excess_reg;
        skip_pending_next = skip_pending_reg;
        out_valid_next    = out_valid_reg;
        out_res_next      = out_res_reg;
        out_wb_next       = out_wb_reg;
        out_skip_next     = out_skip_reg;
        out_pass_next     = out_pass_reg;
        out_ex_next       = out_ex_reg;

        s_ready = (state_reg == sbalu_pkg::ST_IDLE);
        commit  = 1'b0;

        // multiply: conditional add of multiplicand; divide: trial subtract
        if (op_reg == sbalu_pkg::OP_MUL || op_reg == sbalu_pkg::OP_MLI) begin
            add_x   = {1'b0, rem_reg};
            add_y   = dq_reg[0] ? {1'b0, dvsr_reg} : 17'h0;
            add_sub = 1'b0;
        end else begin
            add_x   = {rem_reg, dq_reg[31]};
            add_y   = {1'b0, dvsr_reg};
            add_sub = 1'b1;
        end

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            sbalu_pkg::ST_IDLE: begin
                if (s_valid) begin
                    op_next       = s_req_type;
                    b_next        = s_b_value;
                    a_next        = s_a_value;
                    dvsr_next     = mag_a;
                    rem_next      = 16'h0;
                    skip_now_next = in_skip;
                    if (is_mul) begin
                        dq_next  = {16'h0, mag_b};
                        neg_next = s_b_value[15] ^ s_a_value[15];
                        cnt_next = sbalu_pkg::ITER_HALF;
                    end else begin
                        dq_next  = {mag_b, 16'h0};
                        neg_next = is_mod ? s_b_value[15] : (s_b_value[15] ^ s_a_value[15]);
                        cnt_next = is_div ? sbalu_pkg::ITER_FULL : sbalu_pkg::ITER_HALF;
                    end
                    if (!is_signed_op) begin
                        neg_next = 1'b0;
                    end
                    if (!in_skip && (is_mul || ((is_div || is_mod) && !in_a_zero))) begin
                        state_next = sbalu_pkg::ST_CALC;
                    end else begin
                        state_next = sbalu_pkg::ST_WRAP;
                    end
                end
            end
            sbalu_pkg::ST_CALC: begin
                if (op_reg == sbalu_pkg::OP_MUL || op_reg == sbalu_pkg::OP_MLI) begin
                    rem_next = add_res[16:1];
                    dq_next  = {dq_reg[31:16], add_res[0], dq_reg[15:1]};
                end else if (add_res[17]) begin
                    rem_next = add_x[15:0];
                    dq_next  = {dq_reg[30:0], 1'b0};
                end else begin
                    rem_next = add_res[15:0];
                    dq_next  = {dq_reg[30:0], 1'b1};
                end
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    state_next = sbalu_pkg::ST_WRAP;
                end
            end
            sbalu_pkg::ST_WRAP: begin
                if (!out_valid_reg || m_ready) begin
                    commit         = 1'b1;
                    state_next     = sbalu_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                    if (skip_now_reg) begin
                        skip_pending_next = 1'b0;
                        out_res_next  = 16'h0;
                        out_wb_next   = 1'b0;
                        out_skip_next = 1'b1;
                        out_pass_next = 1'b0;
                        out_ex_next   = excess_reg;
                    end else begin
                        excess_next   = w_ex;
                        if (w_cond) begin
                            skip_pending_next = !w_pass;
                        end
                        out_res_next  = w_res;
                        out_wb_next   = w_wb;
                        out_skip_next = 1'b0;
                        out_pass_next = w_pass;
                        out_ex_next   = w_ex;
                    end
                end
            end
            default: begin
                state_next = sbalu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= sbalu_pkg::ST_IDLE;
            excess_reg       <= 16'h0;
            skip_pending_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            excess_reg       <= excess_next;
            skip_pending_reg <= skip_pending_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        b_reg        <= b_next;
        a_reg        <= a_next;
        dvsr_reg     <= dvsr_next;
        rem_reg      <= rem_next;
        dq_reg       <= dq_next;
        cnt_reg      <= cnt_next;
        neg_reg      <= neg_next;
        skip_now_reg <= skip_now_next;
        out_res_reg  <= out_res_next;
        out_wb_reg   <= out_wb_next;
        out_skip_reg <= out_skip_next;
        out_pass_reg <= out_pass_next;
        out_ex_reg   <= out_ex_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_result_value = out_res_reg;
    assign m_write_back   = out_wb_reg;
    assign m_was_skipped  = out_skip_reg;
    assign m_test_passed  = out_pass_reg;
    assign m_excess_out   = out_ex_reg;

    // a skipped word carries no result and no test outcome
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_was_skipped |-> !m_write_back && !m_test_passed
                                     && (m_result_value == 16'h0))
        else $error("skipped word carries a result");

    // write-back and test outcome exclude each other
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_write_back && m_test_passed))
        else $error("write-back and test pass both set");

    // one word in flight: input closes after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // every committed word leaves EX visible on the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_valid && (m_excess_out == excess_reg))
        else $error("excess output out of step with EX");

endmodule

@@ dv/tb_sixteen_bit_alu_with_excess_register.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for sixteen_bit_alu_with_excess_register: a directed table
// and random words, checked against a behavioral ALU with its own EX and skip state.
// Depends on sbalu_pkg and the block's RTL.
module tb_sixteen_bit_alu_with_excess_register;
    import sbalu_pkg::*;

    localparam logic [OpWidth-1:0] OP_SPARE = 5'd31;
    localparam int NumDirected = 30;
    localparam int NumRandom   = 400;
    localparam int NumCalm     = 60;
    localparam int HoldAfter   = 80;
    localparam int HoldCycles  = 150;
    localparam int DrainCycles = 40;
    localparam int QuietLimit  = 1000;

    typedef struct packed {
        logic [15:0] value;
        logic        write_back;
        logic        was_skipped;
        logic        test_passed;
        logic [15:0] excess;
    } alu_word_t;

    typedef struct packed {
        logic [4:0]  op;
        logic [15:0] b;
        logic [15:0] a;
        logic        typed;
        alu_word_t   want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [4:0]  s_req_type;
    logic [15:0] s_b_value;
    logic [15:0] s_a_value;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_result_value;
    logic        m_write_back;
    logic        m_was_skipped;
    logic        m_test_passed;
    logic [15:0] m_excess_out;

    logic [15:0] ex_track;
    logic        skip_track;
    alu_word_t   expected_words[$];
    stim_row_t   dir_rows [NumDirected];
    bit          calm = 1'b0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          n_alu = 0;
    int          n_skipped = 0;
    int          n_held = 0;
    int          n_other = 0;

    sixteen_bit_alu_with_excess_register i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_b_value      (s_b_value),
        .s_a_value      (s_a_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_write_back   (m_write_back),
        .m_was_skipped  (m_was_skipped),
        .m_test_passed  (m_test_passed),
        .m_excess_out   (m_excess_out)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic alu_word_t predict_alu(input logic [4:0] op, input logic [15:0] b,
                                              input logic [15:0] a);
        alu_word_t         w;
        logic [31:0]       wide;
        logic signed [31:0] swide;
        logic [17:0]       sum;
        longint            sq;
        logic [15:0]       ex;
        ex = ex_track;
        w = '0;
        if (skip_track) begin
            skip_track = 1'b0;
            w.was_skipped = 1'b1;
        end else if (op <= OP_SBX) begin
            w.write_back = 1'b1;
            case (op)
                OP_SET: w.value = a;
                OP_ADD: begin
                    sum = b + a;
                    w.value = sum[15:0];
                    ex = {15'd0, sum[16]};
                end
                OP_SUB: begin
                    w.value = b - a;
                    ex = (a > b) ? ALL_ONES : 16'h0000;
                end
                OP_MUL: begin
                    wide = b * a;
                    w.value = wide[15:0];
                    ex = wide[31:16];
                end
                OP_MLI: begin
                    sq = longint'($signed(b)) * longint'($signed(a));
                    w.value = sq[15:0];
                    ex = sq[31:16];
                end
                OP_DIV: begin
                    if (a == 16'h0000) begin
                        ex = 16'h0000;
                    end else begin
                        w.value = b / a;
                        wide = {b, 16'h0000} / a;
                        ex = wide[15:0];
                    end
                end
                OP_DVI: begin
                    if (a == 16'h0000) begin
                        ex = 16'h0000;
                    end else begin
                        sq = longint'($signed(b)) / longint'($signed(a));
                        w.value = sq[15:0];
                        sq = (longint'($signed(b)) * 65536) / longint'($signed(a));
                        ex = sq[15:0];
                    end
                end
                OP_MOD: w.value = (a == 16'h0000) ? 16'h0000 : b % a;
                OP_MDI: begin
                    if (a != 16'h0000) begin
                        sq = longint'($signed(b)) % longint'($signed(a));
                        w.value = sq[15:0];
                    end
                end
                OP_AND: w.value = b & a;
                OP_BOR: w.value = b | a;
                OP_XOR: w.value = b ^ a;
                OP_SHR: begin
                    w.value = b >> a;
                    wide = {b, 16'h0000} >> a;
                    ex = wide[15:0];
                end
                OP_ASR: begin
                    swide = $signed({b, 16'h0000});
                    swide = swide >>> a;
                    w.value = swide[31:16];
                    ex = swide[15:0];
                end
                OP_SHL: begin
                    wide = {16'h0000, b} << a;
                    w.value = wide[15:0];
                    ex = wide[31:16];
                end
                OP_ADX: begin
                    sum = b + a + ex;
                    w.value = sum[15:0];
                    ex = (sum > 18'h0ffff) ? 16'h0001 : 16'h0000;
                end
                default: begin
                    sq = longint'(b) - longint'(a) + longint'(ex);
                    w.value = sq[15:0];
                    ex = (sq < 0) ? ALL_ONES : ((sq > 65535) ? 16'h0001 : 16'h0000);
                end
            endcase
        end else if (op <= OP_IFU) begin
            case (op)
                OP_IFB: w.test_passed = (b & a) != 16'h0000;
                OP_IFC: w.test_passed = (b & a) == 16'h0000;
                OP_IFE: w.test_passed = b == a;
                OP_IFN: w.test_passed = b != a;
                OP_IFG: w.test_passed = b > a;
                OP_IFA: w.test_passed = $signed(b) > $signed(a);
                OP_IFL: w.test_passed = b < a;
                default: w.test_passed = $signed(b) < $signed(a);
            endcase
            skip_track = !w.test_passed;
        end
        ex_track = ex;
        w.excess = ex;
        return w;
    endfunction

    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return ALL_ONES;
            2: return 16'h8000;
            3: return 16'h7fff;
            4: return 16'($urandom_range(0, 40));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatches < 40)
            $display("MISMATCH word %0d %s: got %h, want %h", results_seen, field, got, want);
        mismatches++;
    endtask

    task automatic check_word();
        alu_word_t want;
        if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", m_result_value, 16'h0000);
            return;
        end
        want = expected_words.pop_front();
        if (m_result_value !== want.value)
            report_mismatch("result_value", m_result_value, want.value);
        if (m_write_back !== want.write_back)
            report_mismatch("write_back", 16'(m_write_back), 16'(want.write_back));
        if (m_was_skipped !== want.was_skipped)
            report_mismatch("was_skipped", 16'(m_was_skipped), 16'(want.was_skipped));
        if (m_test_passed !== want.test_passed)
            report_mismatch("test_passed", 16'(m_test_passed), 16'(want.test_passed));
        if (m_excess_out !== want.excess)
            report_mismatch("excess_out", m_excess_out, want.excess);
        if (want.write_back)
            n_alu++;
        else if (want.was_skipped)
            n_skipped++;
        else if (want.test_passed)
            n_held++;
        else
            n_other++;
        results_seen++;
    endtask

    task automatic send_word(input logic [4:0] op, input logic [15:0] b, input logic [15:0] a,
                             input logic typed, input alu_word_t want);
        alu_word_t   predicted;
        int unsigned gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= op;
        s_b_value  <= b;
        s_a_value  <= a;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_alu(op, b, a);
        expected_words.insert(expected_words.size(), typed ? want : predicted);
    endtask

    // result side: random stalls, one long hold-off to back up the input
    initial begin : sink
        int unsigned stall_left;
        bit          hold_done;
        stall_left = 0;
        hold_done = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                check_word();
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && results_seen >= HoldAfter) begin
                hold_done = 1'b1;
                stall_left = HoldCycles - 1;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 4);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QuietLimit) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no handshake for %0d cycles, %0d words outstanding",
                 QuietLimit, expected_words.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [4:0]  op;
        logic [15:0] b;
        logic [15:0] a;
        int unsigned pick;
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_req_type <= OP_SET;
        s_b_value  <= 16'h0000;
        s_a_value  <= 16'h0000;
        ex_track   = 16'h0000;
        skip_track = 1'b0;
        dir_rows = '{
            '{OP_SET, 16'h0000, 16'hffff, 1'b1, '{16'hffff, 1'b1, 1'b0, 1'b0, 16'h0000}},
            '{OP_ADD, 16'hffff, 16'h0001, 1'b1, '{16'h0000, 1'b1, 1'b0, 1'b0, 16'h0001}},
            '{OP_ADX, 16'hffff, 16'hffff, 1'b1, '{16'hffff, 1'b1, 1'b0, 1'b0, 16'h0001}},
            '{OP_SUB, 16'h0000, 16'h0001, 1'b1, '{16'hffff, 1'b1, 1'b0, 1'b0, 16'hffff}},
            '{OP_SBX, 16'h0000, 16'h0000, 1'b1, '{16'hffff, 1'b1, 1'b0, 1'b0, 16'h0000}},
            '{OP_SBX, 16'h0000, 16'hffff, 1'b1, '{16'h0001, 1'b1, 1'b0, 1'b0, 16'hffff}},
            '{OP_SBX, 16'hffff, 16'h0000, 1'b1, '{16'hfffe, 1'b1, 1'b0, 1'b0, 16'h0001}},
            '{OP_MUL, 16'hffff, 16'hffff, 1'b1, '{16'h0001, 1'b1, 1'b0, 1'b0, 16'hfffe}},
            '{OP_MLI, 16'h8000, 16'h8000, 1'b1, '{16'h0000, 1'b1, 1'b0, 1'b0, 16'h4000}},
            '{OP_MOD, 16'hffff, 16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b0, 1'b0, 16'h4000}},
            '{OP_MDI, 16'h8000, 16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b0, 1'b0, 16'h4000}},
            '{OP_DVI, 16'h7fff, 16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000}},
            '{OP_DIV, 16'h1234, 16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000}},
            '{OP_DVI, 16'h8000, 16'hffff, 1'b1, '{16'h8000, 1'b1, 1'b0, 1'b0, 16'h0000}},
            '{OP_SHR, 16'hffff, 16'h0020, 1'b1, '{16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000}},
            '{OP_ASR, 16'h8000, 16'hffff, 1'b1, '{16'hffff, 1'b1, 1'b0, 1'b0, 16'hffff}},
            '{OP_SHL, 16'hffff, 16'h001f, 1'b0, '0},
            '{OP_AND, 16'hffff, 16'h5a5a, 1'b0, '0},
            '{OP_BOR, 16'h00ff, 16'ha500, 1'b0, '0},
            '{OP_XOR, 16'hffff, 16'h5a5a, 1'b0, '0},
            '{OP_IFE, 16'h0001, 16'h0002, 1'b0, '0},
            '{OP_IFN, 16'h0001, 16'h0002, 1'b0, '0},
            '{OP_SPARE, 16'hffff, 16'hffff, 1'b0, '0},
            '{OP_IFB, 16'h00f0, 16'h0f10, 1'b0, '0},
            '{OP_IFC, 16'h00f0, 16'h0f00, 1'b0, '0},
            '{OP_IFG, 16'hffff, 16'h0000, 1'b0, '0},
            '{OP_IFA, 16'h7fff, 16'h8000, 1'b0, '0},
            '{OP_IFL, 16'h0000, 16'hffff, 1'b0, '0},
            '{OP_IFU, 16'h7fff, 16'h8000, 1'b0, '0},
            '{OP_ADD, 16'hffff, 16'hffff, 1'b0, '0}
        };
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NumDirected; i++)
            send_word(dir_rows[i].op, dir_rows[i].b, dir_rows[i].a,
                      dir_rows[i].typed, dir_rows[i].want);

        for (int i = 0; i < NumRandom; i++) begin
            calm = (i >= NumRandom - NumCalm);
            pick = $urandom_range(0, 19);
            if (pick < 12)
                op = 5'($urandom_range(0, 16));
            else if (pick < 18)
                op = 5'($urandom_range(17, 24));
            else
                op = 5'($urandom_range(25, 31));
            b = pick_operand();
            a = pick_operand();
            if (op >= OP_IFB && op <= OP_IFU && $urandom_range(0, 3) == 0)
                a = b;
            send_word(op, b, a, 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (expected_words.size() != 0)
            @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        $display("Covered %0d words: %0d executed ops, %0d tests held, %0d skipped,",
                 results_seen, n_alu, n_held, n_skipped);
        $display("  %0d failed tests or spare opcodes; %0d mismatches after a %0d-cycle hold-off",
                 n_other, mismatches, HoldCycles);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
